// ===== sv/icle_pkg.sv =====
// ----------------------------------------------------------------------------
// icle_pkg
// Shared types and constants for the indexed circular list engine.
// ----------------------------------------------------------------------------
package icle_pkg;

   localparam int ENTRIES_DEFAULT = 256;
   localparam int ID_W            = 8;
   localparam int FUNC_W          = 4;
   localparam int COUNT_W         = 9;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [FUNC_W-1:0] {
      FN_INS_AFTER = 4'd0,
      FN_INS_FRONT = 4'd1,
      FN_INS_BACK  = 4'd2,
      FN_DELETE    = 4'd3,
      FN_POP_FIRST = 4'd4,
      FN_POP_LAST  = 4'd5,
      FN_REPLACE   = 4'd6,
      FN_NEXT      = 4'd7,
      FN_PREV      = 4'd8
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD1,
      ST_RD2,
      ST_WR1,
      ST_WR2,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ID_W-1:0]   target_id;
      logic [ID_W-1:0]   other_id;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]    result_id;
      logic               result_valid;
      logic [ID_W-1:0]    head_id;
      logic               head_valid;
      logic [ID_W-1:0]    tail_id;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   // one link memory access: read address, optional write
   typedef struct packed {
      logic            rd_en;
      logic [ID_W-1:0] rd_addr;
      logic            wr_en;
      logic [ID_W-1:0] wr_addr;
      logic [ID_W-1:0] wr_data;
   } link_cmd_type;

endpackage

// ===== sv/icle_if.sv =====
// ----------------------------------------------------------------------------
// icle_req_if / icle_rsp_if
// Valid/ready channels carrying command and result beats.
// ----------------------------------------------------------------------------
interface icle_req_if;
   import icle_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface icle_rsp_if;
   import icle_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/icle_link_mem.sv =====
// ----------------------------------------------------------------------------
// icle_link_mem
// One link memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module icle_link_mem #(
   parameter int ENTRIES = icle_pkg::ENTRIES_DEFAULT
) (
   input  logic                       clock,
   input  icle_pkg::link_cmd_type     cmd,
   output logic [icle_pkg::ID_W-1:0]  rd_data
);
   import icle_pkg::*;

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [ID_W-1:0] mem [ENTRIES];
   logic [AW-1:0]   wa, ra;

   // id modulo ENTRIES as a constant lookup over all id values
   function automatic logic [AW-1:0] wrap_id(logic [ID_W-1:0] id);
      logic [AW-1:0] r;
      r = '0;
      for (int i = 0; i < 2**ID_W; i++) begin
         if (id == ID_W'(i)) r = AW'(i % ENTRIES);
      end
      return r;
   endfunction

   always_comb begin
      wa = wrap_id(cmd.wr_addr);
      ra = wrap_id(cmd.rd_addr);
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wa] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data <= mem[ra];
      end
   end
endmodule

// ===== sv/icle_ctrl.sv =====
// ----------------------------------------------------------------------------
// icle_ctrl
// Command sequencer: reads links, writes back up to four links, updates
// head, tail, flag and count, and holds the result beat.
// ----------------------------------------------------------------------------
module icle_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   icle_req_if.sink                  req,
   icle_rsp_if.source                rsp,
   output icle_pkg::link_cmd_type    prev_cmd,
   output icle_pkg::link_cmd_type    next_cmd,
   input  logic [icle_pkg::ID_W-1:0] prev_rd,
   input  logic [icle_pkg::ID_W-1:0] next_rd
);
   import icle_pkg::*;

   state_type          state_ff, state_in;
   req_type            cmd_ff, cmd_in;
   logic [ID_W-1:0]    e_ff, e_in, o_ff, o_in;   // effective entry / anchor
   logic [ID_W-1:0]    p_ff, p_in, n_ff, n_in;   // fetched neighbors
   logic [ID_W-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic               ne_ff, ne_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [ID_W-1:0]    res_ff, res_in;
   logic               rv_ff, rv_in;
   logic               ins_ff, ins_in;           // insert: single or linked

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         ne_ff    <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         ne_ff    <= ne_in;
         cnt_ff   <= cnt_in;
      end
      cmd_ff <= cmd_in;
      e_ff   <= e_in;
      o_ff   <= o_in;
      p_ff   <= p_in;
      n_ff   <= n_in;
      res_ff <= res_in;
      rv_ff  <= rv_in;
      ins_ff <= ins_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      e_in     = e_ff;
      o_in     = o_ff;
      p_in     = p_ff;
      n_in     = n_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      ne_in    = ne_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      rv_in    = rv_ff;
      ins_in   = ins_ff;
      prev_cmd = '0;
      next_cmd = '0;
      req.ready   = 1'b0;
      rsp.valid   = 1'b0;
      rsp.payload = '0;

      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               cmd_in = req.payload;
               e_in   = req.payload.target_id;
               o_in   = req.payload.other_id;
               res_in = '0;
               rv_in  = 1'b0;
               ins_in = 1'b0;
               state_in = ST_DONE;
               case (req.payload.func)
                  FN_INS_AFTER, FN_INS_FRONT, FN_INS_BACK: begin
                     ins_in = 1'b1;
                     if (!ne_ff) begin
                        state_in = ST_WR1;  // becomes a single entry
                     end else begin
                        if (req.payload.func == FN_INS_BACK) o_in = tail_ff;
                        if (req.payload.func == FN_INS_FRONT) o_in = head_ff;
                        state_in = ST_RD1;
                     end
                  end
                  FN_DELETE, FN_POP_FIRST, FN_POP_LAST: begin
                     if (ne_ff) begin
                        if (req.payload.func == FN_POP_FIRST) e_in = head_ff;
                        if (req.payload.func == FN_POP_LAST) e_in = tail_ff;
                        if (req.payload.func != FN_DELETE) begin
                           res_in = (req.payload.func == FN_POP_FIRST) ? head_ff : tail_ff;
                           rv_in  = 1'b1;
                        end
                        if (head_ff == tail_ff) begin
                           head_in = '0;
                           tail_in = '0;
                           ne_in   = 1'b0;
                           cnt_in  = '0;
                        end else begin
                           state_in = ST_RD1;
                        end
                     end
                  end
                  FN_REPLACE, FN_NEXT, FN_PREV: begin
                     if (ne_ff) state_in = ST_RD1;
                  end
                  default: ;
               endcase
            end
         end

         ST_RD1: begin
            // read prev and next of the entry (anchor for inserts)
            prev_cmd.rd_en   = 1'b1;
            next_cmd.rd_en   = 1'b1;
            prev_cmd.rd_addr = ins_ff ? o_ff : e_ff;
            next_cmd.rd_addr = ins_ff ? o_ff : e_ff;
            state_in = ST_RD2;
         end

         ST_RD2: begin
            p_in = prev_rd;
            n_in = next_rd;
            state_in = ST_WR1;
            case (cmd_ff.func)
               FN_NEXT: begin
                  if (next_rd != head_ff) begin
                     res_in = next_rd;
                     rv_in  = 1'b1;
                  end
                  state_in = ST_DONE;
               end
               FN_PREV: begin
                  if (prev_rd != tail_ff) begin
                     res_in = prev_rd;
                     rv_in  = 1'b1;
                  end
                  state_in = ST_DONE;
               end
               FN_REPLACE: begin
                  if (prev_rd == e_ff) p_in = o_ff;
                  if (next_rd == e_ff) n_in = o_ff;
               end
               default: ;
            endcase
         end

         ST_WR1: begin
            prev_cmd.wr_en = 1'b1;
            next_cmd.wr_en = 1'b1;
            state_in = ST_WR2;
            case (cmd_ff.func)
               FN_INS_AFTER, FN_INS_FRONT, FN_INS_BACK: begin
                  prev_cmd.wr_addr = e_ff;
                  next_cmd.wr_addr = e_ff;
                  if (!ne_ff) begin
                     prev_cmd.wr_data = e_ff;
                     next_cmd.wr_data = e_ff;
                     head_in  = e_ff;
                     tail_in  = e_ff;
                     ne_in    = 1'b1;
                     state_in = ST_DONE;
                     if (cnt_ff != COUNT_MAX) cnt_in = cnt_ff + 1'b1;
                  end else if (cmd_ff.func == FN_INS_FRONT) begin
                     // anchor o = head, p = its prev
                     prev_cmd.wr_data = p_ff;
                     next_cmd.wr_data = o_ff;
                  end else begin
                     prev_cmd.wr_data = o_ff;
                     next_cmd.wr_data = n_ff;
                  end
               end
               FN_REPLACE: begin
                  prev_cmd.wr_addr = o_ff;
                  next_cmd.wr_addr = o_ff;
                  prev_cmd.wr_data = p_ff;
                  next_cmd.wr_data = n_ff;
               end
               default: begin
                  // unlink: next[p] = n, prev[n] = p
                  prev_cmd.wr_en   = 1'b0;
                  next_cmd.wr_addr = p_ff;
                  next_cmd.wr_data = n_ff;
                  prev_cmd.wr_en   = 1'b1;
                  prev_cmd.wr_addr = n_ff;
                  prev_cmd.wr_data = p_ff;
                  if (e_ff == head_ff) head_in = n_ff;
                  else if (e_ff == tail_ff) tail_in = p_ff;
                  if (cnt_ff != '0) cnt_in = cnt_ff - 1'b1;
                  state_in = ST_DONE;
               end
            endcase
         end

         ST_WR2: begin
            prev_cmd.wr_en = 1'b1;
            next_cmd.wr_en = 1'b1;
            state_in = ST_DONE;
            case (cmd_ff.func)
               FN_INS_FRONT: begin
                  prev_cmd.wr_addr = o_ff;
                  prev_cmd.wr_data = e_ff;
                  next_cmd.wr_addr = p_ff;
                  next_cmd.wr_data = e_ff;
                  head_in = e_ff;
                  if (cnt_ff != COUNT_MAX) cnt_in = cnt_ff + 1'b1;
               end
               FN_INS_AFTER, FN_INS_BACK: begin
                  next_cmd.wr_addr = o_ff;
                  next_cmd.wr_data = e_ff;
                  prev_cmd.wr_addr = n_ff;
                  prev_cmd.wr_data = e_ff;
                  if (tail_ff == o_ff) tail_in = e_ff;
                  if (cnt_ff != COUNT_MAX) cnt_in = cnt_ff + 1'b1;
               end
               default: begin
                  // replace
                  next_cmd.wr_addr = p_ff;
                  next_cmd.wr_data = o_ff;
                  prev_cmd.wr_addr = n_ff;
                  prev_cmd.wr_data = o_ff;
                  if (e_ff == head_ff) head_in = o_ff;
                  if (e_ff == tail_ff) tail_in = o_ff;
               end
            endcase
         end

         ST_DONE: begin
            rsp.valid = 1'b1;
            rsp.payload.result_id    = rv_ff ? res_ff : '0;
            rsp.payload.result_valid = rv_ff;
            rsp.payload.head_id      = ne_ff ? head_ff : '0;
            rsp.payload.head_valid   = ne_ff;
            rsp.payload.tail_id      = ne_ff ? tail_ff : '0;
            rsp.payload.entry_count  = cnt_ff;
            if (rsp.ready) state_in = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ===== sv/indexed_circular_list_engine.sv =====
// ----------------------------------------------------------------------------
// indexed_circular_list_engine
// Circular doubly linked list over entry ids, links held in two memories.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one command beat (func, target_id, other_id).
//   rsp channel: one result beat per command, with head, tail and count
//   as they stand after the command.
//   One command in flight at a time. From accept to result valid, the
//     sequencer goes straight to DONE for commands that touch no link
//     (empty list, clear of a one-entry list, unused codes), through RD1,
//     RD2 for next/prev, WR1 for the first insert into an empty list, RD1,
//     RD2, WR1 for delete/pop, and RD1, RD2, WR1, WR2 for inserts into a
//     non-empty list and replace. The steps are set by the registered read
//     of the link memories and by their single write port each.
//   A new command is taken only once the sequencer is back in idle.
//   Reset clears head, tail, the non-empty flag and the count; the link
//   memories are not cleared, an unwritten link reads as garbage.
//   A stalled rsp beat holds and no new command is taken until it leaves.
// ----------------------------------------------------------------------------
module indexed_circular_list_engine #(
   parameter int ENTRIES = icle_pkg::ENTRIES_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   icle_req_if.sink    req,
   icle_rsp_if.source  rsp
);
   import icle_pkg::*;

   link_cmd_type    prev_cmd, next_cmd;
   logic [ID_W-1:0] prev_rd, next_rd;

   icle_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .rsp      (rsp),
      .prev_cmd (prev_cmd),
      .next_cmd (next_cmd),
      .prev_rd  (prev_rd),
      .next_rd  (next_rd)
   );

   // previous links
   icle_link_mem #(.ENTRIES(ENTRIES)) u_prev_mem (
      .clock   (clock),
      .cmd     (prev_cmd),
      .rd_data (prev_rd)
   );

   // next links
   icle_link_mem #(.ENTRIES(ENTRIES)) u_next_mem (
      .clock   (clock),
      .cmd     (next_cmd),
      .rd_data (next_rd)
   );
endmodule
